### sv/pbb_pkg.sv
// package for the point set with bounding box block
// holds table sizing, operation codes, point and box types and box helpers
// no dependencies
package pbb_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int PC_W = 7;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CONTAINS = 2'd2;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
	} point_t;

	typedef struct packed {
		logic signed [31:0] min_x;
		logic signed [31:0] min_y;
		logic signed [31:0] max_x;
		logic signed [31:0] max_y;
	} box_t;

	typedef struct packed {
		logic hit;
		logic accepted;
		logic [CNT_W-1:0] count;
		box_t box;
	} res_t;

	function automatic box_t box_from_point(point_t p);
		box_t b;
		b.min_x = p.px;
		b.max_x = p.px;
		b.min_y = p.py;
		b.max_y = p.py;
		return b;
	endfunction

	function automatic box_t box_widen(box_t b, point_t p);
		box_t r;
		r = b;
		if (p.px < b.min_x) r.min_x = p.px;
		if (p.py < b.min_y) r.min_y = p.py;
		if (p.px > b.max_x) r.max_x = p.px;
		if (p.py > b.max_y) r.max_y = p.py;
		return r;
	endfunction

endpackage

### sv/point_set_with_bounding_box.sv
// top level of the point set with bounding box: sequencer plus result register
// depends on pbb_pkg and pbb_ctrl
// add and unused codes, and remove or contains on an empty table, finish without a scan;
// remove and contains otherwise scan the table ram one entry per cycle (contains stops at the first match)
// throughput: one operation at a time; busy is high during a scan
// reset clears count, box, state and done; the table needs no clearing; results cannot stall
module point_set_with_bounding_box (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               busy,
	output logic               done,
	output logic               hit,
	output logic               accepted,
	output logic [6:0]         point_count,
	output logic signed [31:0] min_x,
	output logic signed [31:0] min_y,
	output logic signed [31:0] max_x,
	output logic signed [31:0] max_y
);

	logic fin;
	pbb_pkg::res_t res;
	pbb_pkg::res_t res_q;
	logic done_q;

	pbb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.busy   (busy),
		.fin    (fin),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			res_q <= res;
		end
	end

	assign done = done_q;
	assign hit = res_q.hit;
	assign accepted = res_q.accepted;
	assign point_count = pbb_pkg::PC_W'(res_q.count);
	assign min_x = res_q.box.min_x;
	assign min_y = res_q.box.min_y;
	assign max_x = res_q.box.max_x;
	assign max_y = res_q.box.max_y;

endmodule

### sv/pbb_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
module pbb_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/pbb_ctrl.sv
// sequencer for the point set: count and box registers, table scan with compaction
// depends on pbb_pkg and pbb_ram
module pbb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         op,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic               busy,
	output logic               fin,
	output pbb_pkg::res_t      res
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic [pbb_pkg::CNT_W-1:0] count_q;
	logic [pbb_pkg::CNT_W-1:0] count_d;
	pbb_pkg::box_t box_q;
	pbb_pkg::box_t box_d;
	pbb_pkg::box_t acc_q;
	pbb_pkg::box_t acc_nxt;
	logic acc_vld_q;
	logic acc_vld_nxt;
	logic found_q;
	logic found_all;
	logic [1:0] op_q;
	pbb_pkg::point_t pt_q;
	pbb_pkg::point_t pt_in;
	pbb_pkg::point_t ent;
	logic [pbb_pkg::IDX_W-1:0] idx_q;
	logic accept;
	logic full;
	logic go_scan;
	logic match;
	logic last;
	logic fin_scan;
	logic we;
	logic [pbb_pkg::IDX_W-1:0] waddr;
	pbb_pkg::point_t wdata;
	logic re;
	logic [pbb_pkg::IDX_W-1:0] raddr;
	logic [$bits(pbb_pkg::point_t)-1:0] rdata;

	pbb_ram #(
		.DEPTH(pbb_pkg::TABLE_DEPTH),
		.WIDTH($bits(pbb_pkg::point_t))
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		accept = start && (state_q == ST_IDLE);
		busy = (state_q != ST_IDLE);
		full = (count_q == pbb_pkg::CNT_W'(pbb_pkg::TABLE_DEPTH));
		pt_in.px = x_coord;
		pt_in.py = y_coord;
		ent = pbb_pkg::point_t'(rdata);
		match = (ent == pt_q) && !found_q;
		found_all = found_q || match;
		acc_vld_nxt = acc_vld_q || !match;
		if (match) begin
			acc_nxt = acc_q;
		end else if (acc_vld_q) begin
			acc_nxt = pbb_pkg::box_widen(acc_q, ent);
		end else begin
			acc_nxt = pbb_pkg::box_from_point(ent);
		end
		last = ((pbb_pkg::CNT_W'(idx_q) + pbb_pkg::CNT_W'(1)) >= count_q);
		fin_scan = (state_q == ST_SCAN) && (last || ((op_q == pbb_pkg::OP_CONTAINS) && match));
		go_scan = accept && (count_q != '0)
			&& ((op == pbb_pkg::OP_REMOVE) || (op == pbb_pkg::OP_CONTAINS));

		count_d = count_q;
		box_d = box_q;
		fin = 1'b0;
		res.hit = 1'b0;
		res.accepted = 1'b0;
		we = 1'b0;
		waddr = count_q[pbb_pkg::IDX_W-1:0];
		wdata = pt_in;
		re = 1'b0;
		raddr = '0;

		if (accept) begin
			fin = !go_scan;
			re = go_scan;
			if ((op == pbb_pkg::OP_ADD) && !full) begin
				res.accepted = 1'b1;
				we = 1'b1;
				count_d = count_q + pbb_pkg::CNT_W'(1);
				if (count_q == '0) begin
					box_d = pbb_pkg::box_from_point(pt_in);
				end else begin
					box_d = pbb_pkg::box_widen(box_q, pt_in);
				end
			end
		end else if (state_q == ST_SCAN) begin
			re = !fin_scan;
			raddr = idx_q + pbb_pkg::IDX_W'(1);
			if ((op_q == pbb_pkg::OP_REMOVE) && found_q) begin
				we = 1'b1;
				waddr = idx_q - pbb_pkg::IDX_W'(1);
				wdata = ent;
			end
			if (fin_scan) begin
				fin = 1'b1;
				res.hit = found_all;
				if ((op_q == pbb_pkg::OP_REMOVE) && found_all) begin
					count_d = count_q - pbb_pkg::CNT_W'(1);
					box_d = acc_vld_nxt ? acc_nxt : '0;
				end
			end
		end
		res.count = count_d;
		res.box = box_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			box_q <= '0;
			found_q <= 1'b0;
			acc_vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			count_q <= count_d;
			box_q <= box_d;
			if (accept) begin
				idx_q <= '0;
				found_q <= 1'b0;
				acc_vld_q <= 1'b0;
				if (go_scan) begin
					state_q <= ST_SCAN;
				end
			end else if (state_q == ST_SCAN) begin
				idx_q <= idx_q + pbb_pkg::IDX_W'(1);
				found_q <= found_all;
				acc_vld_q <= acc_vld_nxt;
				if (fin_scan) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			pt_q <= pt_in;
		end
		if (state_q == ST_SCAN) begin
			acc_q <= acc_nxt;
		end
	end

endmodule

### sv/pbb_checker.sv
// port level checks for point_set_with_bounding_box, attached by bind
// depends on pbb_pkg
module pbb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic [1:0]         op,
	input logic               busy,
	input logic               done,
	input logic               hit,
	input logic               accepted,
	input logic [6:0]         point_count,
	input logic signed [31:0] min_x,
	input logic signed [31:0] min_y,
	input logic signed [31:0] max_x,
	input logic signed [31:0] max_y
);

	a_add_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (op == pbb_pkg::OP_ADD)) |=> (done && !busy))
		else $error("add transfer did not complete in one cycle");

	a_hit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit && accepted))
		else $error("hit and accepted both set");

	a_empty_box: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (point_count == 7'd0)) |->
		((min_x == 0) && (min_y == 0) && (max_x == 0) && (max_y == 0)))
		else $error("empty table with nonzero box");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((min_x <= max_x) && (min_y <= max_y)))
		else $error("box bounds out of order");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> (point_count != 7'd0))
		else $error("accepted add left an empty count");

endmodule

bind point_set_with_bounding_box pbb_checker u_pbb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.op         (op),
	.busy       (busy),
	.done       (done),
	.hit        (hit),
	.accepted   (accepted),
	.point_count(point_count),
	.min_x      (min_x),
	.min_y      (min_y),
	.max_x      (max_x),
	.max_y      (max_y)
);

### tb/point_set_with_bounding_box_tb.sv
// testbench for point_set_with_bounding_box: directed and random add, remove,
// contains and unused-code transfers checked against a behavioral point table
// depends on pbb_pkg and the point_set_with_bounding_box rtl
module point_set_with_bounding_box_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 450;
	localparam int RING_DEPTH = 8;

	typedef struct {
		logic            hit;
		logic            accepted;
		logic [6:0]      count;
		pbb_pkg::box_t   box;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic [1:0]         op;
	logic signed [31:0] x_coord;
	logic signed [31:0] y_coord;
	logic               busy;
	logic               done;
	logic               hit;
	logic               accepted;
	logic [6:0]         point_count;
	logic signed [31:0] min_x;
	logic signed [31:0] min_y;
	logic signed [31:0] max_x;
	logic signed [31:0] max_y;

	pbb_pkg::point_t held_points [pbb_pkg::TABLE_DEPTH];
	int              fill;
	pbb_pkg::box_t   held_box;
	outcome_t        want_ring [RING_DEPTH];
	int              ring_wr;
	int              ring_rd;

	int  errors;
	int  results_checked;
	int  op_tally [4];
	int  peak_fill;
	int  dropped_adds;
	int  cycle_count;
	bit  gaps_on;

	point_set_with_bounding_box dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.op         (op),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.busy       (busy),
		.done       (done),
		.hit        (hit),
		.accepted   (accepted),
		.point_count(point_count),
		.min_x      (min_x),
		.min_y      (min_y),
		.max_x      (max_x),
		.max_y      (max_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycle_count);
		$display("point_set_with_bounding_box_tb failed");
		$finish;
	end

	function automatic void stretch_box(pbb_pkg::point_t p);
		if (p.px < held_box.min_x) held_box.min_x = p.px;
		if (p.py < held_box.min_y) held_box.min_y = p.py;
		if (p.px > held_box.max_x) held_box.max_x = p.px;
		if (p.py > held_box.max_y) held_box.max_y = p.py;
	endfunction

	function automatic int locate_point(pbb_pkg::point_t p);
		for (int i = 0; i < fill; i++)
			if (held_points[i] == p) return i;
		return fill;
	endfunction

	function automatic outcome_t apply_to_point_set(logic [1:0] code, pbb_pkg::point_t p);
		outcome_t o;
		int at;
		o.hit = 1'b0;
		o.accepted = 1'b0;
		unique case (code)
			pbb_pkg::OP_ADD: begin
				if (fill < pbb_pkg::TABLE_DEPTH) begin
					if (fill == 0) begin
						held_box.min_x = p.px;
						held_box.max_x = p.px;
						held_box.min_y = p.py;
						held_box.max_y = p.py;
					end else begin
						stretch_box(p);
					end
					held_points[fill] = p;
					fill++;
					o.accepted = 1'b1;
				end
			end
			pbb_pkg::OP_REMOVE: begin
				at = locate_point(p);
				if (at < fill) begin
					o.hit = 1'b1;
					for (int i = at; i + 1 < fill; i++)
						held_points[i] = held_points[i + 1];
					fill--;
					held_box = '0;
					if (fill > 0) begin
						held_box.min_x = held_points[0].px;
						held_box.max_x = held_points[0].px;
						held_box.min_y = held_points[0].py;
						held_box.max_y = held_points[0].py;
						for (int i = 1; i < fill; i++)
							stretch_box(held_points[i]);
					end
				end
			end
			pbb_pkg::OP_CONTAINS: begin
				if (locate_point(p) < fill) o.hit = 1'b1;
			end
			default: begin
			end
		endcase
		o.count = fill[6:0];
		o.box = held_box;
		return o;
	endfunction

	function automatic logic signed [31:0] extreme_value();
		unique case ($urandom_range(0, 4))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return 32'sd1;
		endcase
	endfunction

	function automatic pbb_pkg::point_t pick_point();
		pbb_pkg::point_t p;
		int mode;
		mode = $urandom_range(0, 99);
		if (fill > 0 && mode < 40) begin
			p = held_points[$urandom_range(0, fill - 1)];
		end else if (mode < 70) begin
			p.px = int'($urandom_range(0, 4)) - 2;
			p.py = int'($urandom_range(0, 4)) - 2;
		end else if (mode < 85) begin
			p.px = $urandom;
			p.py = $urandom;
		end else begin
			p.px = extreme_value();
			p.py = extreme_value();
		end
		return p;
	endfunction

	function automatic pbb_pkg::point_t absent_point();
		pbb_pkg::point_t p;
		do begin
			p.px = $urandom;
			p.py = $urandom;
		end while (locate_point(p) != fill);
		return p;
	endfunction

	// called just after a falling edge, returns just after a falling edge with start high
	task automatic send_op(logic [1:0] code, logic signed [31:0] xv, logic signed [31:0] yv);
		pbb_pkg::point_t p;
		outcome_t o;
		if (gaps_on && $urandom_range(0, 99) < 20) begin
			start = 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		p.px = xv;
		p.py = yv;
		start = 1'b1;
		op = code;
		x_coord = xv;
		y_coord = yv;
		do @(posedge clk); while (busy);
		@(negedge clk);
		o = apply_to_point_set(code, p);
		want_ring[ring_wr % RING_DEPTH] = o;
		ring_wr++;
		op_tally[code]++;
		if (fill > peak_fill) peak_fill = fill;
		if (code == pbb_pkg::OP_ADD && o.accepted == 1'b0) dropped_adds++;
	endtask

	task automatic send_point(logic [1:0] code, pbb_pkg::point_t p);
		send_op(code, p.px, p.py);
	endtask

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	initial begin
		outcome_t want;
		forever begin
			@(posedge clk);
			if (arst_n && done) begin
				if (ring_wr == ring_rd) begin
					$display("%0t: unexpected result, expected none, got count %0d",
						$time, point_count);
					errors++;
				end else begin
					want = want_ring[ring_rd % RING_DEPTH];
					ring_rd++;
					results_checked++;
					check_field("hit", want.hit, hit);
					check_field("accepted", want.accepted, accepted);
					check_field("point_count", want.count, point_count);
					check_field("min_x", want.box.min_x, min_x);
					check_field("min_y", want.box.min_y, min_y);
					check_field("max_x", want.box.max_x, max_x);
					check_field("max_y", want.box.max_y, max_y);
				end
			end
		end
	end

	task automatic test_empty_table();
		send_op(pbb_pkg::OP_REMOVE, 0, 0);
		send_op(pbb_pkg::OP_CONTAINS, 0, 0);
		send_op(OP_UNUSED, -1, -1);
		send_op(pbb_pkg::OP_ADD, 5, -7);
		send_op(pbb_pkg::OP_REMOVE, 5, -7);
		send_op(pbb_pkg::OP_CONTAINS, 5, -7);
	endtask

	task automatic test_extremes();
		send_op(pbb_pkg::OP_ADD, S32_MIN, S32_MAX);
		send_op(pbb_pkg::OP_ADD, S32_MAX, S32_MIN);
		send_op(pbb_pkg::OP_ADD, 0, 0);
		send_op(pbb_pkg::OP_ADD, -1, -1);
		send_op(pbb_pkg::OP_CONTAINS, S32_MAX, S32_MIN);
		send_op(pbb_pkg::OP_CONTAINS, S32_MAX, S32_MAX);
		send_op(OP_UNUSED, S32_MAX, S32_MIN);
		send_op(pbb_pkg::OP_REMOVE, S32_MIN, S32_MAX);
		send_op(pbb_pkg::OP_REMOVE, S32_MAX, S32_MIN);
		send_op(pbb_pkg::OP_REMOVE, 0, 0);
		send_op(pbb_pkg::OP_REMOVE, -1, -1);
	endtask

	task automatic test_duplicates();
		send_op(pbb_pkg::OP_ADD, 3, 3);
		send_op(pbb_pkg::OP_ADD, -4, 9);
		send_op(pbb_pkg::OP_ADD, 3, 3);
		send_op(pbb_pkg::OP_REMOVE, 3, 3);
		send_op(pbb_pkg::OP_CONTAINS, 3, 3);
		send_op(pbb_pkg::OP_REMOVE, 3, 3);
		send_op(pbb_pkg::OP_CONTAINS, 3, 3);
		send_op(pbb_pkg::OP_REMOVE, -4, 9);
	endtask

	task automatic test_full_table();
		pbb_pkg::point_t p;
		while (fill < pbb_pkg::TABLE_DEPTH) send_point(pbb_pkg::OP_ADD, pick_point());
		repeat (3) send_point(pbb_pkg::OP_ADD, pick_point());
		send_point(pbb_pkg::OP_CONTAINS, held_points[pbb_pkg::TABLE_DEPTH - 1]);
		send_point(pbb_pkg::OP_CONTAINS, absent_point());
		send_point(pbb_pkg::OP_REMOVE, absent_point());
		send_op(OP_UNUSED, S32_MIN, S32_MAX);
		p = held_points[pbb_pkg::TABLE_DEPTH - 1];
		send_point(pbb_pkg::OP_REMOVE, p);
		send_point(pbb_pkg::OP_ADD, p);
		send_point(pbb_pkg::OP_ADD, pick_point());
		while (fill > 0)
			send_point(pbb_pkg::OP_REMOVE, held_points[$urandom_range(0, fill - 1)]);
		send_op(pbb_pkg::OP_REMOVE, 0, 0);
	endtask

	// phases lean toward adding, mixing, then removing, and the sequence repeats, so the fill level sweeps the table
	task automatic test_random_mix();
		int pct;
		int add_pct;
		int remove_pct;
		logic [1:0] code;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			gaps_on = !(i >= 250 && i < 400);
			unique case ((i / 100) % 3)
				0: begin add_pct = 65; remove_pct = 15; end
				1: begin add_pct = 35; remove_pct = 35; end
				default: begin add_pct = 15; remove_pct = 60; end
			endcase
			pct = $urandom_range(0, 99);
			if (pct < 3) code = OP_UNUSED;
			else if (pct < 3 + add_pct) code = pbb_pkg::OP_ADD;
			else if (pct < 3 + add_pct + remove_pct) code = pbb_pkg::OP_REMOVE;
			else code = pbb_pkg::OP_CONTAINS;
			send_point(code, pick_point());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = pbb_pkg::OP_ADD;
		x_coord = '0;
		y_coord = '0;
		fill = 0;
		held_box = '0;
		ring_wr = 0;
		ring_rd = 0;
		errors = 0;
		results_checked = 0;
		peak_fill = 0;
		dropped_adds = 0;
		gaps_on = 1'b1;
		foreach (op_tally[i]) op_tally[i] = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_table();
		test_extremes();
		test_duplicates();
		test_full_table();
		test_random_mix();

		start = 1'b0;
		while (ring_wr != ring_rd) @(posedge clk);
		repeat (pbb_pkg::TABLE_DEPTH + 10) @(posedge clk);

		$display("covered %0d adds (%0d dropped on a full table), %0d removes,",
			op_tally[pbb_pkg::OP_ADD], dropped_adds, op_tally[pbb_pkg::OP_REMOVE]);
		$display("%0d lookups, %0d unused codes, %0d results compared, peak fill %0d, %0d errors",
			op_tally[pbb_pkg::OP_CONTAINS], op_tally[OP_UNUSED], results_checked,
			peak_fill, errors);
		if (errors == 0) begin
			$display("point_set_with_bounding_box_tb passed");
		end else begin
			$display("point_set_with_bounding_box_tb failed");
		end
		$finish;
	end

endmodule

### sim.f
sv/pbb_pkg.sv
sv/pbb_ram.sv
sv/pbb_ctrl.sv
sv/point_set_with_bounding_box.sv
sv/pbb_checker.sv
tb/point_set_with_bounding_box_tb.sv
